// File: rtl/core/assert_macros.svh
// Assertion macros shared by the whole_word_first_replace RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define WWFR_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define WWFR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/wwfr_pkg.sv
// Shared types, constants and helpers of the whole-word find and replace block.
package wwfr_pkg;

  localparam int MAX_TERM_DEF = 8;
  localparam int TERM_W       = 64;
  localparam int LEN_W        = 4;
  localparam int CFG_IDX_W    = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIND_WORD    = 2'd0,
    REG_FIND_LEN     = 2'd1,
    REG_REPLACE_WORD = 2'd2,
    REG_REPLACE_LEN  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ECLOSE,
    S_FLUSH,
    S_REPL,
    S_TAIL,
    S_NULL
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EMIT_STORE,
    EMIT_REPL,
    EMIT_CHAR,
    EMIT_NULL
  } emit_sel_t;

  typedef struct packed {
    logic      load_item;
    logic      store_char;
    logic      set_overlong;
    logic      clr_overlong;
    logic      clr_count;
    logic      set_replaced;
    logic      end_line;
    logic      idx_clr;
    logic      idx_inc;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } dp_cmd_t;

  typedef struct packed {
    logic char_ok;
    logic at_space;
    logic item_end;
    logic overlong;
    logic can_store;
    logic hit;
    logic count_zero;
    logic rlen_zero;
    logic flush_done;
    logic repl_done;
    logic out_free;
  } dp_status_t;

  // Byte i of a term word, first character in the lowest byte.
  function automatic logic [7:0] term_byte(input logic [TERM_W-1:0] word,
                                           input logic [2:0] i);
    term_byte = word[{i, 3'b000} +: 8];
  endfunction

endpackage

// File: rtl/core/wwfr_if.sv
// Stream interfaces for the character input and the rewritten output.
interface wwfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_char_valid;
  logic       in_line_end;

  modport source (output valid, output in_char, output in_char_valid,
                  output in_line_end, input ready);
  modport sink (input valid, input in_char, input in_char_valid,
                input in_line_end, output ready);
endinterface

interface wwfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_line_last;

  modport source (output valid, output out_char, output out_char_valid,
                  output out_line_last, input ready);
  modport sink (input valid, input out_char, input out_char_valid,
                input out_line_last, output ready);
endinterface

// File: rtl/core/wwfr_ctrl.sv
// Sequencer that steps one character transaction through its emission phases.
`include "assert_macros.svh"

module wwfr_ctrl import wwfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        tail_pend, tail_pend_next;
  logic        at_end, at_end_next;
  logic        close_emits;
  ctrl_state_t close_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tail_pend <= 1'b0;
      at_end    <= 1'b0;
    end else begin
      state     <= state_next;
      tail_pend <= tail_pend_next;
      at_end    <= at_end_next;
    end
  end

  // A word close emits the replacement on a hit, else flushes the buffered word, when there is anything to emit.
  assign close_emits = st.hit ? !st.rlen_zero : !st.count_zero;
  assign close_state = st.hit ? S_REPL : S_FLUSH;

  always_comb begin
    state_next     = state;
    tail_pend_next = tail_pend;
    at_end_next    = at_end;
    cmd            = '0;
    in_ready       = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_EVAL;
        end
      end
      S_EVAL: begin
        if (st.char_ok) begin
          if (st.at_space) begin
            tail_pend_next   = 1'b1;
            at_end_next      = 1'b0;
            cmd.clr_overlong = 1'b1;
            if (st.hit) begin
              cmd.set_replaced = 1'b1;
              cmd.clr_count    = 1'b1;
            end
            if (close_emits) begin
              cmd.idx_clr = 1'b1;
              state_next  = close_state;
            end else begin
              state_next = S_TAIL;
            end
          end else if (st.overlong) begin
            state_next = S_TAIL;
          end else if (st.can_store) begin
            cmd.store_char = 1'b1;
            state_next     = st.item_end ? S_ECLOSE : S_IDLE;
          end else begin
            cmd.set_overlong = 1'b1;
            tail_pend_next   = 1'b1;
            at_end_next      = 1'b0;
            if (!st.count_zero) begin
              cmd.idx_clr = 1'b1;
              state_next  = S_FLUSH;
            end else begin
              state_next = S_TAIL;
            end
          end
        end else begin
          state_next = st.item_end ? S_ECLOSE : S_IDLE;
        end
      end
      S_ECLOSE: begin
        tail_pend_next   = 1'b0;
        at_end_next      = 1'b1;
        cmd.clr_overlong = 1'b1;
        if (st.hit) begin
          cmd.set_replaced = 1'b1;
          cmd.clr_count    = 1'b1;
        end
        if (close_emits) begin
          cmd.idx_clr = 1'b1;
          state_next  = close_state;
        end else begin
          state_next = S_NULL;
        end
      end
      S_FLUSH: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_STORE;
          cmd.emit_last = at_end && st.flush_done;
          cmd.idx_inc   = 1'b1;
          if (st.flush_done) begin
            // Before a tail only the count is cleared; the end of line clears it along with the rest of the word state.
            if (tail_pend) begin
              cmd.clr_count = 1'b1;
              state_next    = S_TAIL;
            end else begin
              cmd.end_line = 1'b1;
              state_next   = S_IDLE;
            end
          end
        end
      end
      S_REPL: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_REPL;
          cmd.emit_last = at_end && st.repl_done;
          cmd.idx_inc   = 1'b1;
          if (st.repl_done) begin
            if (tail_pend) begin
              state_next = S_TAIL;
            end else begin
              cmd.end_line = 1'b1;
              state_next   = S_IDLE;
            end
          end
        end
      end
      S_TAIL: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_CHAR;
          cmd.emit_last = st.item_end;
          cmd.end_line  = st.item_end;
          state_next    = S_IDLE;
        end
      end
      S_NULL: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = EMIT_NULL;
          cmd.emit_last = 1'b1;
          cmd.end_line  = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `WWFR_ASSERT_IMP(a_emit_needs_slot, cmd.emit, st.out_free, "emit without a free output slot")
  `WWFR_ASSERT(a_close_context, !(tail_pend && at_end), "tail and end-of-line close both pending")
  `WWFR_ASSERT_IMP(a_store_allowed, cmd.store_char, st.can_store, "store into a full word buffer")

endmodule

// File: rtl/core/wwfr_datapath.sv
// Word buffer, term registers, match logic and output register.
`include "assert_macros.svh"

module wwfr_datapath import wwfr_pkg::*; #(
  parameter int MAX_TERM = MAX_TERM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TERM_W-1:0]    cfg_data,
  input  logic [7:0]           in_char,
  input  logic                 in_char_valid,
  input  logic                 in_line_end,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [7:0]           out_char,
  output logic                 out_char_valid,
  output logic                 out_line_last,
  input  dp_cmd_t              cmd,
  output dp_status_t           st
);

  localparam int CNT_W = $clog2(MAX_TERM + 1);
  localparam int IDX_W = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;

  logic [TERM_W-1:0] find_bytes, replace_word;
  logic [LEN_W-1:0]  find_len, replace_len;

  logic [7:0]        item_char;
  logic              item_ok;
  logic              item_end;

  logic [7:0]        store [MAX_TERM];
  logic [CNT_W-1:0]  count;
  logic              overlong;
  logic              replaced;
  logic [IDX_W-1:0]  idx;

  logic [CNT_W-1:0]  flen_eff, rlen_eff, idx_plus;
  logic              bytes_eq;
  logic [7:0]        emit_char;
  logic              emit_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      find_bytes   <= '0;
      find_len     <= LEN_W'(1);
      replace_word <= '0;
      replace_len  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIND_WORD:    find_bytes   <= cfg_data;
        REG_FIND_LEN:     find_len     <= cfg_data[LEN_W-1:0];
        REG_REPLACE_WORD: replace_word <= cfg_data;
        REG_REPLACE_LEN:  replace_len  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Lengths above the buffer depth saturate to it.
  assign flen_eff = (find_len > LEN_W'(MAX_TERM)) ? CNT_W'(MAX_TERM) : CNT_W'(find_len);
  assign rlen_eff = (replace_len > LEN_W'(MAX_TERM)) ? CNT_W'(MAX_TERM)
                                                     : CNT_W'(replace_len);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_char <= in_char;
      item_ok   <= in_char_valid && !(in_line_end && in_char == CHAR_NL);
      item_end  <= in_line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      store[count[IDX_W-1:0]] <= item_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overlong <= 1'b0;
      replaced <= 1'b0;
    end else begin
      if (cmd.store_char) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.clr_count) begin
        count <= '0;
      end
      if (cmd.set_overlong) begin
        overlong <= 1'b1;
      end
      if (cmd.clr_overlong) begin
        overlong <= 1'b0;
      end
      if (cmd.set_replaced) begin
        replaced <= 1'b1;
      end
      if (cmd.end_line) begin
        count    <= '0;
        overlong <= 1'b0;
        replaced <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
  end

  // Whole-word compare against the find term.
  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_TERM; i++) begin
      if (CNT_W'(i) < flen_eff && store[i] != term_byte(find_bytes, 3'(i))) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign idx_plus = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    st.char_ok    = item_ok;
    st.at_space   = item_char == CHAR_SPACE;
    st.item_end   = item_end;
    st.overlong   = overlong;
    st.can_store  = count < flen_eff;
    st.hit        = !overlong && !replaced && flen_eff != '0 && count == flen_eff && bytes_eq;
    st.count_zero = count == '0;
    st.rlen_zero  = rlen_eff == '0;
    st.flush_done = idx_plus == count;
    st.repl_done  = idx_plus == rlen_eff;
    st.out_free   = !out_valid || out_ready;
  end

  always_comb begin
    emit_char  = CHAR_NUL;
    emit_valid = 1'b1;
    case (cmd.emit_sel)
      EMIT_STORE: emit_char = store[idx];
      EMIT_REPL:  emit_char = term_byte(replace_word, 3'(idx));
      EMIT_CHAR:  emit_char = item_char;
      EMIT_NULL:  emit_valid = 1'b0;
      default:    emit_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_char       <= emit_char;
      out_char_valid <= emit_valid;
      out_line_last  <= cmd.emit_last;
    end
  end

  `WWFR_ASSERT_IMP(a_null_is_last, out_valid && !out_char_valid, out_line_last, "empty result not last")
  `WWFR_ASSERT(a_count_bound, count <= CNT_W'(MAX_TERM), "word count beyond buffer depth")

endmodule

// File: rtl/core/whole_word_first_replace.sv
// Top level of the whole-word, first-occurrence find and replace block.
//
//  Channel      Role        Transaction
//  line_chars   sink        one character, its valid flag and end-of-line flag
//  line_result  source      one rewritten character, its valid flag and last flag
//  cfg_*        write port  one register write: cfg_index selects, cfg_data holds value
//
// A character transaction is accepted in S_IDLE and evaluated in S_EVAL, then
// emits its results; an end-of-line transaction whose character is buffered,
// empty or a dropped newline also passes through S_ECLOSE for the word compare.
// A space, or the first character past the find length, can release up to nine
// results from the word buffer or replace term, one per cycle when not stalled.
// The synchronous reset clears the sequencer, the word state, the output register
// and the configuration registers; there is no clearing pass. When line_result
// stalls, the output register holds its result and the sequencer waits on it.
`include "assert_macros.svh"

module whole_word_first_replace import wwfr_pkg::*; #(
  parameter int MAX_TERM = MAX_TERM_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  wwfr_in_if.sink              line_chars,
  wwfr_out_if.source           line_result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TERM_W-1:0]    cfg_data
);

  // The sequencer and the datapath talk only through these two structs.
  dp_cmd_t    cmd;
  dp_status_t st;

  // Input is taken only while the sequencer is idle; the output register
  // decouples it, so the next character can be accepted while the previous
  // transaction's final result still waits on line_result.
  wwfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (line_chars.valid),
    .in_ready (line_chars.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath owns the word buffer, the find and replace terms, the
  // whole-word compare and the registered output slot.
  wwfr_datapath #(
    .MAX_TERM (MAX_TERM)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_char        (line_chars.in_char),
    .in_char_valid  (line_chars.in_char_valid),
    .in_line_end    (line_chars.in_line_end),
    .out_ready      (line_result.ready),
    .out_valid      (line_result.valid),
    .out_char       (line_result.out_char),
    .out_char_valid (line_result.out_char_valid),
    .out_line_last  (line_result.out_line_last),
    .cmd            (cmd),
    .st             (st)
  );

  // An input transaction is only ever taken while no emission is in flight.
  `WWFR_ASSERT_IMP(a_accept_quiet, line_chars.valid && line_chars.ready, !cmd.emit, "input taken during emission")

endmodule
